// ----- hdl/hsp_pkg.sv -----
// hsp_pkg: widths, character codes, prefix tables and types for the status line parser
// no dependencies; imported by the channel interfaces, the parser and its checker
package hsp_pkg;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 10;
    localparam int POS_W  = 4;

    localparam logic [CODE_W-1:0] CODE_MAX = CODE_W'(999);

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
    localparam logic [BYTE_W-1:0] CH_I     = 8'h49;

    localparam logic [POS_W-1:0] HTTP_PREFIX_LEN = 4'd7;
    localparam logic [POS_W-1:0] HTTP_MINOR_POS  = 4'd7;
    localparam logic [POS_W-1:0] HTTP_SPACE_POS  = 4'd8;
    localparam logic [POS_W-1:0] HTTP_CODE_LAST  = 4'd11;
    localparam logic [POS_W-1:0] HTTP_DONE_POS   = 4'd12;
    localparam logic [POS_W-1:0] ICY_PREFIX_LEN  = 4'd4;
    localparam logic [POS_W-1:0] ICY_CODE_LAST   = 4'd6;
    localparam logic [POS_W-1:0] ICY_DONE_POS    = 4'd7;
    localparam logic [POS_W-1:0] POS_MAX         = 4'd15;

    typedef enum logic [1:0] {
        PK_UNDECIDED = 2'd0,
        PK_HTTP      = 2'd1,
        PK_ICY       = 2'd2
    } prefix_kind_t;

    // expected byte of "HTTP/1." at a position
    function automatic logic [BYTE_W-1:0] http_char(input logic [2:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2f;
            3'd5:    c = 8'h31;
            3'd6:    c = 8'h2e;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // expected byte of "ICY " at a position
    function automatic logic [BYTE_W-1:0] icy_char(input logic [1:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            2'd0:    c = 8'h49;
            2'd1:    c = 8'h43;
            2'd2:    c = 8'h59;
            default: c = 8'h20;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/hsp_if.sv -----
// hsp_line_if and hsp_result_if: valid/ready channels of the status line parser
// depends on hsp_pkg for the field widths
interface hsp_line_if
    import hsp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] line_byte;
    logic              line_end;

    modport source (output valid, output line_byte, output line_end, input ready);
    modport sink   (input valid, input line_byte, input line_end, output ready);
endinterface

interface hsp_result_if
    import hsp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              has_byte;
    logic [BYTE_W-1:0] message_byte;
    logic              done_res;
    logic              protocol_minor;
    logic [CODE_W-1:0] status_code;
    logic              malformed;

    modport source (output valid, output has_byte, output message_byte, output done_res,
                    output protocol_minor, output status_code, output malformed,
                    input ready);
    modport sink   (input valid, input has_byte, input message_byte, input done_res,
                    input protocol_minor, input status_code, input malformed,
                    output ready);
endinterface

// ----- hdl/http_status_line_parser.sv -----
// http_status_line_parser: byte-serial HTTP/1.x and ICY status line parser
// depends on hsp_pkg and the channel interfaces in hsp_if.sv
//
// usage
// - line: one request per byte of the status line, line_end set on the last byte
// - result: one request per reason message byte (has_byte set) and one for the
//   last byte of a line (done_res set, with protocol_minor, status_code, malformed);
//   bytes of the prefix and code, and bytes after an error, give no request
// - a byte goes into an input register; the parse logic then updates the
//   line state and fills the result register, which drives result.valid, so
//   an accepted byte passes the input register and then the result register
// - one byte is accepted every cycle; the only limit is the result register,
//   which must be free or be emptied in the same cycle
// - when result.ready is low the result holds; a byte that gives no result
//   still passes, a byte that gives one waits in the input register and
//   line.ready drops once that register is full
// - reset empties both registers and starts a new line; the line state also
//   returns to its start after every line_end byte
module http_status_line_parser
    import hsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    hsp_line_if.sink     line,
    hsp_result_if.source result
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_end_reg;

    logic              out_valid_reg;
    logic              out_has_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_done_reg;
    logic              out_minor_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_malformed_reg;

    logic [POS_W-1:0]  pos_reg, pos_next;
    prefix_kind_t      kind_reg, kind_next;
    logic              minor_reg, minor_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              msg_reg, msg_next;
    logic              err_reg, err_next;

    logic              has;
    logic              ok;
    logic              fin_minor;
    logic [CODE_W-1:0] fin_code;
    logic              res_valid;
    logic              slot_free;
    logic              in_pop;
    logic              is_digit;
    logic [BYTE_W-1:0] digit;
    logic [12:0]       acc;

    assign slot_free  = !out_valid_reg || result.ready;
    assign in_pop     = in_valid_reg && (!res_valid || slot_free);
    assign line.ready = !in_valid_reg || in_pop;

    assign is_digit = (in_byte_reg >= CH_ZERO) && (in_byte_reg <= CH_NINE);
    assign digit    = in_byte_reg - CH_ZERO;
    assign acc      = {code_reg, 3'b000} + {2'b00, code_reg, 1'b0} + {9'd0, digit[3:0]};

    always_comb
    begin
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        minor_next = minor_reg;
        code_next  = code_reg;
        msg_next   = msg_reg;
        err_next   = err_reg;
        has        = 1'b0;

        if (!err_reg)
        begin
            if (msg_reg)
            begin
                has = 1'b1;
            end
            else
            begin
                unique case (kind_reg)
                    PK_UNDECIDED:
                    begin
                        if (in_byte_reg == CH_H)
                            kind_next = PK_HTTP;
                        else if (in_byte_reg == CH_I)
                            kind_next = PK_ICY;
                        else
                            err_next = 1'b1;
                    end
                    PK_HTTP:
                    begin
                        if (pos_reg < HTTP_PREFIX_LEN)
                        begin
                            if (in_byte_reg != http_char(pos_reg[2:0]))
                                err_next = 1'b1;
                        end
                        else if (pos_reg == HTTP_MINOR_POS)
                        begin
                            if (in_byte_reg == CH_ZERO)
                                minor_next = 1'b0;
                            else if (in_byte_reg == CH_ONE)
                                minor_next = 1'b1;
                            else
                                err_next = 1'b1;
                        end
                        else if (pos_reg == HTTP_SPACE_POS)
                        begin
                            if (in_byte_reg != CH_SPACE)
                                err_next = 1'b1;
                        end
                        else if (pos_reg <= HTTP_CODE_LAST)
                        begin
                            if (is_digit)
                                code_next = acc[CODE_W-1:0];
                            else
                                err_next = 1'b1;
                        end
                        else if (in_byte_reg == CH_SPACE)
                            msg_next = 1'b1;
                        else
                            err_next = 1'b1;
                    end
                    PK_ICY:
                    begin
                        if (pos_reg < ICY_PREFIX_LEN)
                        begin
                            if (in_byte_reg != icy_char(pos_reg[1:0]))
                                err_next = 1'b1;
                        end
                        else if (pos_reg <= ICY_CODE_LAST)
                        begin
                            if (is_digit)
                                code_next = acc[CODE_W-1:0];
                            else
                                err_next = 1'b1;
                        end
                        else if (in_byte_reg == CH_SPACE)
                            msg_next = 1'b1;
                        else
                            err_next = 1'b1;
                    end
                    default:
                        err_next = 1'b1;
                endcase

                if (pos_reg < POS_MAX)
                    pos_next = pos_reg + 4'd1;
            end
        end

        ok = !err_next && (msg_next ||
                           (kind_next == PK_HTTP && pos_next == HTTP_DONE_POS) ||
                           (kind_next == PK_ICY && pos_next == ICY_DONE_POS));
        res_valid = in_valid_reg && (has || in_end_reg);

        // result fields come from the values before the end-of-line restart
        fin_minor = minor_next;
        fin_code  = code_next;

        if (in_end_reg)
        begin
            pos_next   = '0;
            kind_next  = PK_UNDECIDED;
            minor_next = 1'b0;
            code_next  = '0;
            msg_next   = 1'b0;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            kind_reg      <= PK_UNDECIDED;
            minor_reg     <= 1'b0;
            code_reg      <= '0;
            msg_reg       <= 1'b0;
            err_reg       <= 1'b0;
        end
        else
        begin
            if (line.valid && line.ready)
                in_valid_reg <= 1'b1;
            else if (in_pop)
                in_valid_reg <= 1'b0;

            if (in_pop && res_valid)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (in_pop)
            begin
                pos_reg   <= pos_next;
                kind_reg  <= kind_next;
                minor_reg <= minor_next;
                code_reg  <= code_next;
                msg_reg   <= msg_next;
                err_reg   <= err_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (line.valid && line.ready)
        begin
            in_byte_reg <= line.line_byte;
            in_end_reg  <= line.line_end;
        end
        if (in_pop && res_valid)
        begin
            out_has_reg       <= has;
            out_byte_reg      <= has ? in_byte_reg : '0;
            out_done_reg      <= in_end_reg;
            out_minor_reg     <= in_end_reg && ok && fin_minor;
            out_code_reg      <= (in_end_reg && ok) ? fin_code : '0;
            out_malformed_reg <= in_end_reg && !ok;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.has_byte       = out_has_reg;
    assign result.message_byte   = out_byte_reg;
    assign result.done_res       = out_done_reg;
    assign result.protocol_minor = out_minor_reg;
    assign result.status_code    = out_code_reg;
    assign result.malformed      = out_malformed_reg;

endmodule

// ----- hdl/hsp_checker.sv -----
// hsp_checker: port-level assertions for http_status_line_parser, attached by bind
// depends on hsp_pkg for widths and the code limit
module hsp_checker
    import hsp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic              has_byte,
    input logic [BYTE_W-1:0] message_byte,
    input logic              done_res,
    input logic              protocol_minor,
    input logic [CODE_W-1:0] status_code,
    input logic              malformed
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(has_byte) &&
        $stable(message_byte) && $stable(done_res) && $stable(status_code) &&
        $stable(malformed) && $stable(protocol_minor))
        else $error("stalled result changed");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !has_byte |-> message_byte == '0)
        else $error("message byte set without has_byte");

    a_done_only: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !done_res |-> !malformed && status_code == '0 && !protocol_minor)
        else $error("line fields set before line end");

    a_malformed_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && malformed |-> status_code == '0 && !protocol_minor)
        else $error("malformed line carries code or version");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> status_code <= CODE_MAX && (has_byte || done_res))
        else $error("bad status code or empty result");

endmodule

bind http_status_line_parser hsp_checker u_hsp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .has_byte       (result.has_byte),
    .message_byte   (result.message_byte),
    .done_res       (result.done_res),
    .protocol_minor (result.protocol_minor),
    .status_code    (result.status_code),
    .malformed      (result.malformed)
);
